// File: design/det_pkg.sv
// ---------------------------------------------------------------------------
// det_pkg: shared types for the distance event tracker
// Entry layout, cell control word, command and result codes.
// ---------------------------------------------------------------------------
`default_nettype none
package det_pkg;

    localparam logic [39:0] OFS_MAX = 40'hFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        FN_ADD_TARGET = 3'd0,
        FN_ADD_DIST   = 3'd1,
        FN_TICK       = 3'd2,
        FN_CANCEL_POS = 3'd3,
        FN_CANCEL_KEY = 3'd4,
        FN_STOP       = 3'd5,
        FN_LEN_CHANGE = 3'd6,
        FN_IMMEDIATE  = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        K_REACHED   = 3'd0,
        K_CANCELLED = 3'd1,
        K_STOPPED   = 3'd2,
        K_DONE      = 3'd3,
        K_FULL      = 3'd4
    } kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic [31:0]        distance;
        logic [31:0]        start;
        logic [39:0]        offset;
        logic [15:0]        key;
        logic signed [31:0] user_a;
        logic signed [31:0] user_b;
        logic [31:0]        tag;
    } entry_t;

    typedef struct packed {
        logic load;   // take the load data (new entry or kept head)
        logic shift;  // take the right neighbor
        logic bump;   // add amount to offset
    } cell_ctl_t;

endpackage
`default_nettype wire

// File: design/distance_event_tracker.sv
// ---------------------------------------------------------------------------
// distance_event_tracker: ordered table of distance-triggered events
// Chain of slot cells with one compare unit at the head of the chain.
// ---------------------------------------------------------------------------
// Usage:
//  - s_ channel carries one command request; m_ channel carries results,
//    one per cycle at most; the final result of a command has m_last=1.
//  - Adds finish at acceptance: the terminal (or error) result is registered at
//    the accepting edge, and the next request can be taken once it is taken.
//  - Length changes and immediates add a finishing pass through ST_SWEEP: the
//    terminal result is registered there once the output register is free
//    (an immediate's reached result comes first).
//  - Tick, cancel and stop rotate the table through the head cell, one entry
//    per cycle while the output register is free; each entry is examined
//    once, then the terminal result follows. The head compare (41-bit add
//    and compare) sets the per-entry step.
//  - Removed entries are emitted in table order; kept entries re-enter the
//    tail of the chain, so the table stays compact and ordered.
//  - s_ready is high only while idle with the output register free.
//  - A stalled m_ready freezes the sweep; nothing is dropped.
//  - Reset (aresetn low, synchronous) empties the table and the output.
//    Slot contents are not cleared; empty slots are never read.
// ---------------------------------------------------------------------------
`default_nettype none
module distance_event_tracker
    import det_pkg::*;
#(
    parameter int TABLE_DEPTH = 32
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [2:0]         s_func,
    input  wire  [31:0]        s_position,
    input  wire  [31:0]        s_distance,
    input  wire  [31:0]        s_amount,
    input  wire  [15:0]        s_key,
    input  wire signed [31:0]  s_user_a,
    input  wire signed [31:0]  s_user_b,
    input  wire  [31:0]        s_tag,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [2:0]         m_kind,
    output logic [15:0]        m_entry_key,
    output logic signed [31:0] m_out_user_a,
    output logic signed [31:0] m_out_user_b,
    output logic [31:0]        m_out_tag,
    output logic [31:0]        m_due_distance,
    output logic [31:0]        m_start_position,
    output logic [31:0]        m_end_position,
    output logic [39:0]        m_offset_sum,
    output logic               m_last
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    state_t      state_reg, state_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] rem_reg, rem_next;
    func_t       mode_reg, mode_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] amt_reg, amt_next;
    logic [15:0] key_reg, key_next;

    // output register
    logic        ov_reg, ov_next;
    kind_t       okind_reg, okind_next;
    entry_t      oent_reg, oent_next;
    logic [31:0] oend_reg, oend_next;
    logic        olast_reg, olast_next;

    entry_t    cells [TABLE_DEPTH];
    cell_ctl_t ctl [TABLE_DEPTH];
    entry_t    new_ent;
    entry_t    head;
    logic      out_free, accept, step, hit, due, keymatch;
    logic [40:0] lhs, rhs;
    logic [31:0] due_dist, cmp_pos;
    logic [CW-1:0] ins_idx;
    logic      do_load, do_shift, do_bump, ins_keep;

    assign out_free = !ov_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign head     = cells[0];

    assign due_dist = (func_t'(s_func) == FN_ADD_TARGET) ?
                      ((s_distance >= s_position) ? s_distance - s_position : 32'd0) :
                      s_distance;
    always_comb begin
        new_ent          = '0;
        new_ent.distance = due_dist;
        new_ent.start    = s_position;
        new_ent.key      = s_key;
        new_ent.user_a   = s_user_a;
        new_ent.user_b   = s_user_b;
        new_ent.tag      = s_tag;
    end

    // head compare: position (or cancel amount) + offset >= start + due
    assign cmp_pos  = (mode_reg == FN_CANCEL_POS) ? amt_reg : pos_reg;
    assign lhs      = {9'd0, cmp_pos} + {1'b0, head.offset};
    assign rhs      = {9'd0, head.start} + {9'd0, head.distance};
    assign due      = lhs >= rhs;
    assign keymatch = (key_reg == 16'd0) || (key_reg == head.key);

    always_comb begin
        case (mode_reg)
            FN_TICK:       hit = due;
            FN_CANCEL_POS: hit = keymatch && due;
            FN_CANCEL_KEY: hit = keymatch;
            default:       hit = 1'b1;
        endcase
    end

    assign step = (state_reg == ST_SWEEP) && out_free && (rem_reg != '0);

    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        amt_next   = amt_reg;
        key_next   = key_reg;
        ov_next    = ov_reg && !m_ready;
        okind_next = okind_reg;
        oent_next  = oent_reg;
        oend_next  = oend_reg;
        olast_next = olast_reg;
        do_load    = 1'b0;
        do_shift   = 1'b0;
        do_bump    = 1'b0;
        ins_keep   = 1'b0;
        ins_idx    = len_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pos_next  = s_position;
                    amt_next  = s_amount;
                    key_next  = s_key;
                    mode_next = func_t'(s_func);
                    rem_next  = '0;
                    unique case (func_t'(s_func)) inside
                        FN_ADD_TARGET, FN_ADD_DIST: begin
                            ov_next    = 1'b1;
                            oent_next  = new_ent;
                            oend_next  = s_position;
                            olast_next = 1'b1;
                            if (len_reg == FULL) begin
                                okind_next = K_FULL;
                            end else begin
                                okind_next = K_DONE;
                                do_load    = 1'b1;
                                len_next   = len_reg + CW'(1);
                            end
                        end
                        FN_LEN_CHANGE: begin
                            do_bump    = 1'b1;
                            state_next = ST_SWEEP;
                        end
                        FN_IMMEDIATE: begin
                            ov_next          = 1'b1;
                            okind_next       = K_REACHED;
                            oent_next        = new_ent;
                            oent_next.distance = s_distance;
                            oend_next        = s_position;
                            olast_next       = 1'b0;
                            state_next       = ST_SWEEP;
                        end
                        default: begin
                            rem_next   = len_reg;
                            state_next = ST_SWEEP;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                if (out_free) begin
                    if (rem_reg == '0) begin
                        ov_next    = 1'b1;
                        okind_next = K_DONE;
                        oent_next  = '0;
                        oend_next  = pos_reg;
                        olast_next = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        do_shift = 1'b1;
                        rem_next = rem_reg - CW'(1);
                        ins_idx  = len_reg - CW'(1);
                        if (hit) begin
                            ov_next    = 1'b1;
                            oent_next  = head;
                            oend_next  = pos_reg;
                            olast_next = 1'b0;
                            len_next   = len_reg - CW'(1);
                            case (mode_reg)
                                FN_TICK: okind_next = K_REACHED;
                                FN_STOP: okind_next = K_STOPPED;
                                default: okind_next = K_CANCELLED;
                            endcase
                        end else begin
                            ins_keep = 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            entry_t right;
            logic   here;
            assign here = (ins_idx[IW-1:0] == IW'(g)) && (ins_idx < FULL);
            if (g == TABLE_DEPTH - 1) begin : g_tail
                assign right = cells[g];
            end else begin : g_mid
                assign right = cells[g+1];
            end
            assign ctl[g].load  = (do_load && here) || (ins_keep && here);
            assign ctl[g].shift = do_shift;
            assign ctl[g].bump  = do_bump;
            det_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl[g]),
                .load_data  (do_load ? new_ent : head),
                .right_data (right),
                .amount     (s_amount),
                .data       (cells[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg   <= '0;
            rem_reg   <= '0;
            ov_reg    <= 1'b0;
            mode_reg  <= FN_TICK;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
            mode_reg  <= mode_next;
        end
        pos_reg   <= pos_next;
        amt_reg   <= amt_next;
        key_reg   <= key_next;
        okind_reg <= okind_next;
        oent_reg  <= oent_next;
        oend_reg  <= oend_next;
        olast_reg <= olast_next;
    end

    assign m_valid          = ov_reg;
    assign m_kind           = okind_reg;
    assign m_entry_key      = oent_reg.key;
    assign m_out_user_a     = oent_reg.user_a;
    assign m_out_user_b     = oent_reg.user_b;
    assign m_out_tag        = oent_reg.tag;
    assign m_due_distance   = oent_reg.distance;
    assign m_start_position = oent_reg.start;
    assign m_end_position   = oend_reg;
    assign m_offset_sum     = oent_reg.offset;
    assign m_last           = olast_reg;

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= FULL) else $error("table length beyond depth");
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= len_reg) else $error("sweep count beyond table length");
    a_len_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !hit |=> len_reg == $past(len_reg)) else $error("kept entry lost");
`endif
endmodule
`default_nettype wire

// File: design/det_cell.sv
// ---------------------------------------------------------------------------
// det_cell: one table slot
// Holds one entry; loads, shifts from its right neighbor or bumps its offset.
// ---------------------------------------------------------------------------
`default_nettype none
module det_cell
    import det_pkg::*;
(
    input  wire         aclk,
    input  cell_ctl_t   ctl,
    input  entry_t      load_data,
    input  entry_t      right_data,
    input  wire  [31:0] amount,
    output entry_t      data
);
    entry_t      data_reg, data_next;
    logic [40:0] sum;

    assign sum = {1'b0, data_reg.offset} + {9'd0, amount};

    always_comb begin
        data_next = data_reg;
        if (ctl.load) begin
            data_next = load_data;
        end else if (ctl.shift) begin
            data_next = right_data;
        end else if (ctl.bump) begin
            data_next.offset = sum[40] ? OFS_MAX : sum[39:0];
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
endmodule
`default_nettype wire

// File: verif/distance_event_tracker_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// distance_event_tracker_tb: self-checking bench for the event tracker
// Drives command requests through directed and random tests, predicts the
// result stream with a behavioral copy of the table, and compares every
// result field by field in arrival order.
// ---------------------------------------------------------------------------
`default_nettype none
module distance_event_tracker_tb;
    import det_pkg::*;

    localparam int DEPTH    = 32;
    localparam int WD_LIMIT = 20000;

    typedef struct {
        kind_t              kind;
        logic [15:0]        key;
        logic signed [31:0] ua;
        logic signed [31:0] ub;
        logic [31:0]        tag;
        logic [31:0]        due;
        logic [31:0]        start;
        logic [31:0]        endp;
        logic [39:0]        ofs;
        logic               last;
    } result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    // request side
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_func = '0;
    logic [31:0]        s_position = '0;
    logic [31:0]        s_distance = '0;
    logic [31:0]        s_amount = '0;
    logic [15:0]        s_key = '0;
    logic signed [31:0] s_user_a = '0;
    logic signed [31:0] s_user_b = '0;
    logic [31:0]        s_tag = '0;

    // result side
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_kind;
    logic [15:0]        m_entry_key;
    logic signed [31:0] m_out_user_a;
    logic signed [31:0] m_out_user_b;
    logic [31:0]        m_out_tag;
    logic [31:0]        m_due_distance;
    logic [31:0]        m_start_position;
    logic [31:0]        m_end_position;
    logic [39:0]        m_offset_sum;
    logic               m_last;

    distance_event_tracker #(.TABLE_DEPTH(DEPTH)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_position(s_position), .s_distance(s_distance), .s_amount(s_amount),
        .s_key(s_key), .s_user_a(s_user_a), .s_user_b(s_user_b), .s_tag(s_tag),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_entry_key(m_entry_key), .m_out_user_a(m_out_user_a),
        .m_out_user_b(m_out_user_b), .m_out_tag(m_out_tag),
        .m_due_distance(m_due_distance), .m_start_position(m_start_position),
        .m_end_position(m_end_position), .m_offset_sum(m_offset_sum),
        .m_last(m_last)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---- predicted table contents (compact, insertion order) ----
    int                 pend_count;
    logic [31:0]        pend_due   [DEPTH];
    logic [31:0]        pend_start [DEPTH];
    logic [39:0]        pend_ofs   [DEPTH];
    logic [15:0]        pend_key   [DEPTH];
    logic signed [31:0] pend_ua    [DEPTH];
    logic signed [31:0] pend_ub    [DEPTH];
    logic [31:0]        pend_tag   [DEPTH];

    result_t expected_results[$];

    int  mismatches = 0;
    int  unexpected = 0;
    int  results_seen = 0;
    int  requests_sent = 0;
    int  func_hits[8];
    int  kind_hits[5];
    int  idle_cycles = 0;
    bit  timed_out = 1'b0;
    bit  burst_mode = 1'b1;   // sender pacing on/off

    function automatic result_t mk(kind_t k, logic [15:0] key, logic [31:0] ua,
                                   logic [31:0] ub, logic [31:0] tag,
                                   logic [31:0] due, logic [31:0] st,
                                   logic [31:0] ep, logic [39:0] ofs, logic l);
        result_t r;
        r.kind = k; r.key = key; r.ua = ua; r.ub = ub; r.tag = tag;
        r.due = due; r.start = st; r.endp = ep; r.ofs = ofs; r.last = l;
        return r;
    endfunction

    // append one predicted result at the tail of the queue
    function automatic void expect_result(result_t r);
        expected_results = {expected_results, r};
    endfunction

    // Due when pos + offset >= start + distance, evaluated at 41 bits.
    function automatic bit entry_due(int i, logic [31:0] pos);
        logic [40:0] lhs, rhs;
        lhs = {9'd0, pos} + {1'b0, pend_ofs[i]};
        rhs = {9'd0, pend_start[i]} + {9'd0, pend_due[i]};
        return lhs >= rhs;
    endfunction

    // Walk the table, emit removed entries in order, compact the rest.
    task automatic sweep_table(func_t fn, logic [31:0] pos, logic [31:0] amt,
                               logic [15:0] key);
        int  keep;
        bit  hit, km;
        kind_t k;
        keep = 0;
        k = (fn == FN_TICK) ? K_REACHED : (fn == FN_STOP) ? K_STOPPED : K_CANCELLED;
        for (int i = 0; i < pend_count; i++) begin
            km = (key == 0) || (key == pend_key[i]);
            case (fn)
                FN_TICK:       hit = entry_due(i, pos);
                FN_CANCEL_POS: hit = km && entry_due(i, amt);
                FN_CANCEL_KEY: hit = km;
                default:       hit = 1'b1;
            endcase
            if (hit) begin
                expect_result(mk(k, pend_key[i], pend_ua[i], pend_ub[i],
                    pend_tag[i], pend_due[i], pend_start[i], pos, pend_ofs[i], 1'b0));
            end else begin
                pend_due[keep] = pend_due[i];   pend_start[keep] = pend_start[i];
                pend_ofs[keep] = pend_ofs[i];   pend_key[keep] = pend_key[i];
                pend_ua[keep] = pend_ua[i];     pend_ub[keep] = pend_ub[i];
                pend_tag[keep] = pend_tag[i];
                keep++;
            end
        end
        pend_count = keep;
    endtask

    // Expected results of one accepted request.
    task automatic predict_request(func_t fn, logic [31:0] pos, logic [31:0] travel,
                                   logic [31:0] amt, logic [15:0] key,
                                   logic [31:0] ua, logic [31:0] ub,
                                   logic [31:0] tag);
        logic [31:0] due;
        logic [40:0] sum;
        case (fn) inside
            FN_ADD_TARGET, FN_ADD_DIST: begin
                due = travel;
                if (fn == FN_ADD_TARGET) due = (travel >= pos) ? travel - pos : 32'd0;
                if (pend_count >= DEPTH) begin
                    expect_result(mk(K_FULL, key, ua, ub, tag, due,
                                     pos, pos, '0, 1'b1));
                end else begin
                    pend_due[pend_count] = due;  pend_start[pend_count] = pos;
                    pend_ofs[pend_count] = '0;   pend_key[pend_count] = key;
                    pend_ua[pend_count] = ua;    pend_ub[pend_count] = ub;
                    pend_tag[pend_count] = tag;
                    pend_count++;
                    expect_result(mk(K_DONE, key, ua, ub, tag, due,
                                     pos, pos, '0, 1'b1));
                end
                return;
            end
            FN_LEN_CHANGE: begin
                for (int i = 0; i < pend_count; i++) begin
                    sum = {1'b0, pend_ofs[i]} + {9'd0, amt};
                    pend_ofs[i] = sum[40] ? OFS_MAX : sum[39:0];
                end
            end
            FN_IMMEDIATE:
                expect_result(mk(K_REACHED, key, ua, ub, tag, travel,
                                 pos, pos, '0, 1'b0));
            default:
                sweep_table(fn, pos, amt, key);
        endcase
        expect_result(mk(K_DONE, '0, '0, '0, '0, '0, '0, pos, '0, 1'b1));
    endtask

    // Send one request: drive on the falling edge, hold until accepted.
    // Returns at the falling edge after acceptance with valid still up;
    // the next request or an idle stretch takes over from there.
    task automatic send_request(func_t fn, logic [31:0] pos, logic [31:0] travel,
                                logic [31:0] amt, logic [15:0] key,
                                logic [31:0] ua, logic [31:0] ub,
                                logic [31:0] tag);
        int gap;
        if (burst_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;      s_position <= pos; s_distance <= travel;
        s_amount <= amt;   s_key <= key;      s_user_a <= ua;
        s_user_b <= ub;    s_tag <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(fn, pos, travel, amt, key, ua, ub, tag);
        func_hits[fn]++;
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out) @(negedge aclk);
        // idle stretch before the next phase
        repeat (DEPTH + 4) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 5000);
            default: return $urandom;
        endcase
    endfunction

    // ---- directed tests ----
    task automatic test_adds_and_extremes();
        send_request(FN_ADD_DIST, 32'd100, 32'd50, '0, 16'd7, 32'sd1, -32'sd1, 32'd9);
        send_request(FN_ADD_TARGET, 32'd100, 32'd400, '0, 16'hFFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        // target behind the position floors at 0
        send_request(FN_ADD_TARGET, 32'd500, 32'd100, '0, 16'd0, '0, '0, '0);
        send_request(FN_ADD_DIST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 16'd3, '1, '1, '1);
        send_request(FN_IMMEDIATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 16'hFFFF,
                     '1, '1, '1);
    endtask

    task automatic test_tick_and_length();
        send_request(FN_TICK, 32'd120, '0, '0, '0, '0, '0, '0);
        send_request(FN_TICK, 32'd200, '0, '0, '0, '0, '0, '0);
        // large offsets on every entry, carried past 32 bits
        send_request(FN_LEN_CHANGE, 32'd0, '0, 32'hFFFF_FFFF, '0, '0, '0, '0);
        repeat (20)
            send_request(FN_LEN_CHANGE, 32'd0, '0, 32'hFFFF_FFFF, '0, '0, '0, '0);
        send_request(FN_TICK, 32'd0, '0, '0, '0, '0, '0, '0);
    endtask

    task automatic test_cancels_and_stop();
        send_request(FN_ADD_DIST, 32'd10, 32'd20, '0, 16'd5, 32'sd2, 32'sd3, 32'd4);
        send_request(FN_ADD_DIST, 32'd10, 32'd90, '0, 16'd0, 32'sd2, 32'sd3, 32'd4);
        send_request(FN_ADD_DIST, 32'd10, 32'd20, '0, 16'd6, 32'sd2, 32'sd3, 32'd4);
        send_request(FN_CANCEL_POS, 32'd11, '0, 32'd35, 16'd5, '0, '0, '0);
        send_request(FN_CANCEL_KEY, 32'd12, '0, '0, 16'd6, '0, '0, '0);
        send_request(FN_CANCEL_POS, 32'd13, '0, 32'hFFFF_FFFF, 16'd0, '0, '0, '0);
        send_request(FN_ADD_DIST, 32'd10, 32'd20, '0, 16'd0, '0, '0, '0);
        send_request(FN_CANCEL_KEY, 32'd14, '0, '0, 16'd9, '0, '0, '0);
        send_request(FN_STOP, 32'hFFFF_FFFF, '1, '1, '1, '1, '1, '1);
    endtask

    task automatic test_full_table();
        for (int i = 0; i <= DEPTH; i++)
            send_request(FN_ADD_DIST, i, $urandom_range(0, 200), '0, i[15:0],
                         $urandom, $urandom, $urandom);
        // everything waits for a complete drain first
        drain_results();
        send_request(FN_STOP, 32'd77, '0, '0, '0, '0, '0, '0);
    endtask

    // Mostly coherent traffic: adds near a moving position, ticks that
    // advance it, with some cancels, length changes, stops and noise.
    task automatic test_random_traffic(int n);
        logic [31:0] line_pos;
        int sel;
        line_pos = $urandom_range(0, 1000);
        for (int j = 0; j < n; j++) begin
            if (j == n / 2) begin
                burst_mode = 1'b0;
                drain_results();
                burst_mode = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 40)
                send_request(($urandom_range(0, 1) != 0) ? FN_ADD_DIST : FN_ADD_TARGET,
                    line_pos, line_pos + $urandom_range(0, 300),
                    $urandom, 16'($urandom_range(0, 4)), $urandom, $urandom, $urandom);
            else if (sel < 70) begin
                line_pos += $urandom_range(0, 120);
                send_request(FN_TICK, line_pos, $urandom, $urandom, 16'($urandom),
                             $urandom, $urandom, $urandom);
            end else if (sel < 76)
                send_request(FN_CANCEL_POS, line_pos, $urandom,
                             line_pos + $urandom_range(0, 200),
                             16'($urandom_range(0, 4)),
                             $urandom, $urandom, $urandom);
            else if (sel < 82)
                send_request(FN_CANCEL_KEY, line_pos, $urandom, $urandom,
                             16'($urandom_range(0, 4)), $urandom, $urandom, $urandom);
            else if (sel < 88)
                send_request(FN_LEN_CHANGE, line_pos, $urandom,
                             $urandom_range(0, 150), 16'($urandom), $urandom, $urandom,
                             $urandom);
            else if (sel < 91)
                send_request(FN_STOP, line_pos, $urandom, $urandom, 16'($urandom),
                             $urandom, $urandom, $urandom);
            else
                send_request(func_t'($urandom_range(0, 7)), rand_word(), rand_word(),
                             rand_word(), 16'($urandom), $urandom, $urandom, rand_word());
        end
    endtask

    // ---- result checker ----
    always @(posedge aclk) begin
        result_t want;
        bit bad;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_kind <= K_FULL) kind_hits[m_kind]++;
            if (expected_results.size() == 0) begin
                unexpected++;
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result kind=%0d key=%0h", m_kind, m_entry_key);
            end else begin
                want = expected_results.pop_front();
                bad = (m_kind !== want.kind) || (m_entry_key !== want.key) ||
                      (m_out_user_a !== want.ua) || (m_out_user_b !== want.ub) ||
                      (m_out_tag !== want.tag) || (m_due_distance !== want.due) ||
                      (m_start_position !== want.start) ||
                      (m_end_position !== want.endp) ||
                      (m_offset_sum !== want.ofs) || (m_last !== want.last);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: result %0d exp kind=%0d key=%h ua=%h ub=%h tag=%h",
                                 results_seen, want.kind, want.key, want.ua, want.ub,
                                 want.tag);
                        $display("       due=%h start=%h end=%h ofs=%h last=%b",
                                 want.due, want.start, want.endp, want.ofs, want.last);
                        $display("       got kind=%0d key=%h ua=%h ub=%h tag=%h",
                                 m_kind, m_entry_key, m_out_user_a, m_out_user_b,
                                 m_out_tag);
                        $display("       due=%h start=%h end=%h ofs=%h last=%b",
                                 m_due_distance, m_start_position, m_end_position,
                                 m_offset_sum, m_last);
                    end
                end
            end
        end
    end

    // receiver: random stall pattern of its own, ready on most cycles
    always @(negedge aclk) begin
        int phase;
        phase = $urandom_range(0, 63);
        if (!aresetn) m_ready <= 1'b0;
        else if (phase < 24) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 2) != 0);
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("ERROR: watchdog, no handshake for %0d cycles", WD_LIMIT);
            $display("FAIL distance_event_tracker");
            $finish;
        end
    end

    initial begin
        pend_count = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_adds_and_extremes();
        test_tick_and_length();
        test_cancels_and_stop();
        test_full_table();
        test_random_traffic(150);

        drain_results();
        $display("Covered %0d requests, %0d results; funcs add %0d/%0d tick %0d",
                 requests_sent, results_seen, func_hits[0], func_hits[1], func_hits[2]);
        $display("cancel %0d/%0d stop %0d len %0d imm %0d; full-table errors %0d",
                 func_hits[3], func_hits[4], func_hits[5], func_hits[6], func_hits[7],
                 kind_hits[K_FULL]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS distance_event_tracker");
        end else begin
            $display("ERROR: %0d mismatches (%0d unexpected), %0d results still expected",
                     mismatches, unexpected, expected_results.size());
            $display("FAIL distance_event_tracker");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
design/det_pkg.sv
design/det_cell.sv
design/distance_event_tracker.sv
verif/distance_event_tracker_tb.sv
